FILE: src/rc_receiver_arming_handler_defines.svh
// Assertion macros shared by the checker of the RC receiver arming handler.
`ifndef RC_RECEIVER_ARMING_HANDLER_DEFINES_SVH
`define RC_RECEIVER_ARMING_HANDLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RCAH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rcah assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RCAH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rcah assertion failed");

`endif

FILE: src/rcah_pkg.sv
// Shared constants, codes and types of the RC receiver arming handler.
`default_nettype none

package rcah_pkg;

    localparam int NumPulses   = 8;
    localparam int NumChannels = 8;
    localparam int PulseW      = 12;
    localparam int TimeW       = 32;
    localparam int ChanIdxW    = 3;
    localparam int NumSticks   = 4;
    localparam int MapW        = 24;
    localparam int SlotKill    = 4;
    localparam int SlotMode    = 5;
    localparam int SlotAux1    = 6;
    localparam int SlotAux2    = 7;
    localparam int SlotYaw     = 2;
    localparam int SlotThrust  = 3;

    localparam logic [PulseW-1:0] PulseMin   = 12'd900;
    localparam logic [PulseW-1:0] PulseMax   = 12'd2200;
    localparam logic [PulseW-1:0] ModeHigh   = 12'd1790;
    localparam logic [PulseW-1:0] ModeMid    = 12'd1240;
    localparam logic [PulseW-1:0] SwitchMid  = 12'd1514;
    localparam logic [TimeW-1:0]  HoldLimit  = 32'd1000;
    localparam logic [TimeW-1:0]  FrameGap   = 32'd20;

    localparam logic [MapW-1:0]   ChannelMapReset  = 24'hFAC688;
    localparam logic [PulseW-1:0] ArmThrottleReset = 12'd1100;
    localparam logic [PulseW-1:0] ArmYawReset      = 12'd1900;
    localparam logic [PulseW-1:0] DisarmYawReset   = 12'd1100;

    typedef logic [PulseW-1:0] pulse_t;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_ARM,
        EV_DISARM,
        EV_KILL
    } arm_event_t;

    typedef enum logic [1:0] {
        MR_NONE,
        MR_MANUAL,
        MR_ATTITUDE
    } mode_request_t;

    typedef enum logic [1:0] {
        MODE_LOW,
        MODE_MID,
        MODE_HIGH
    } mode_pos_t;

    typedef enum logic [1:0] {
        CFG_CHANNEL_MAP,
        CFG_ARM_THROTTLE,
        CFG_ARM_YAW,
        CFG_DISARM_YAW
    } cfg_index_t;

    typedef struct packed {
        logic in_range;
        logic above_switch;
        logic above_mode_mid;
        logic above_mode_high;
    } lane_flags_t;

    typedef struct packed {
        logic [MapW-1:0] channel_map;
        pulse_t          arm_throttle_limit;
        pulse_t          arm_yaw_limit;
        pulse_t          disarm_yaw_limit;
    } cfg_t;

    typedef struct packed {
        logic          accepted;
        logic          rc_lost;
        pulse_t        stick_x;
        pulse_t        stick_y;
        pulse_t        stick_z;
        pulse_t        stick_f;
        logic          kill_on;
        mode_pos_t     mode_position;
        logic          aux1_on;
        logic          aux2_on;
        arm_event_t    arm_event;
        mode_request_t mode_request;
    } result_t;

endpackage

`default_nettype wire

FILE: src/rcah_lane.sv
// One channel lane: range check and switch thresholds of a single pulse width.
`default_nettype none

module rcah_lane
    import rcah_pkg::*;
(
    input  pulse_t      pulse,
    output lane_flags_t flags
);

    always_comb begin
        flags.in_range        = (pulse >= PulseMin) && (pulse <= PulseMax);
        flags.above_switch    = pulse > SwitchMid;
        flags.above_mode_mid  = pulse > ModeMid;
        flags.above_mode_high = pulse > ModeHigh;
    end

endmodule

`default_nettype wire

FILE: src/rcah_merge.sv
// Merging stage: frame gate, failsafe, stick latch and the arm/disarm hold timer.
`default_nettype none

module rcah_merge
    import rcah_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              take,
    input  pulse_t      [NumPulses-1:0]       pulses,
    input  lane_flags_t [NumPulses-1:0]       flags,
    input  logic        [TimeW-1:0]           time_ms,
    input  logic                              is_armed,
    input  cfg_t                              cfg,
    output result_t                           result
);

    logic [TimeW-1:0]          last_frame_reg, last_frame_next;
    logic [TimeW-1:0]          last_check_reg, last_check_next;
    logic [TimeW-1:0]          hold_reg, hold_next;
    pulse_t [NumSticks-1:0]    stick_reg, stick_next;
    logic                      kill_reg, kill_next;
    mode_pos_t                 mode_reg, mode_next;
    logic                      aux1_reg, aux1_next;
    logic                      aux2_reg, aux2_next;

    logic [TimeW-1:0]          gap;
    logic [TimeW-1:0]          dt;
    logic [TimeW:0]            sum;
    logic [TimeW-1:0]          hold_sat;
    logic [TimeW-1:0]          hold_cand;
    logic                      pass;
    logic                      lost;
    logic                      good;
    logic                      in_position;
    pulse_t [NumSticks-1:0]    stick_new;
    logic                      kill_new;
    mode_pos_t                 mode_new;
    logic                      aux1_new;
    logic                      aux2_new;
    lane_flags_t               mode_flags;
    arm_event_t                ev;
    arm_event_t                ev_hold;
    mode_request_t             mr;
    logic [TimeW-1:0]          hold_upd;

    function automatic logic [ChanIdxW-1:0] slot_index(logic [MapW-1:0] map, int slot);
        return map[slot*ChanIdxW +: ChanIdxW];
    endfunction

    always_comb begin
        gap  = time_ms - last_frame_reg;
        pass = gap >= FrameGap;
        lost = 1'b0;
        for (int i = 0; i < NumChannels; i++) begin
            if (!flags[i].in_range) begin
                lost = 1'b1;
            end
        end
        good = pass && !lost;

        for (int s = 0; s < NumSticks; s++) begin
            stick_new[s] = pulses[slot_index(cfg.channel_map, s)];
        end
        kill_new   = flags[slot_index(cfg.channel_map, SlotKill)].above_switch;
        aux1_new   = flags[slot_index(cfg.channel_map, SlotAux1)].above_switch;
        aux2_new   = flags[slot_index(cfg.channel_map, SlotAux2)].above_switch;
        mode_flags = flags[slot_index(cfg.channel_map, SlotMode)];
        if (mode_flags.above_mode_high) begin
            mode_new = MODE_HIGH;
        end else if (mode_flags.above_mode_mid) begin
            mode_new = MODE_MID;
        end else begin
            mode_new = MODE_LOW;
        end

        dt       = time_ms - last_check_reg;
        sum      = {1'b0, hold_reg} + {1'b0, dt};
        hold_sat = sum[TimeW] ? '1 : sum[TimeW-1:0];
        if (is_armed) begin
            in_position = (stick_new[SlotThrust] < cfg.arm_throttle_limit)
                       && (stick_new[SlotYaw] < cfg.disarm_yaw_limit);
            ev_hold     = EV_DISARM;
        end else begin
            in_position = (stick_new[SlotThrust] < cfg.arm_throttle_limit)
                       && (stick_new[SlotYaw] > cfg.arm_yaw_limit);
            ev_hold     = EV_ARM;
        end
        hold_cand = in_position ? hold_sat : '0;

        if (kill_new) begin
            if (hold_cand > HoldLimit) begin
                ev       = ev_hold;
                hold_upd = '0;
            end else begin
                ev       = EV_NONE;
                hold_upd = hold_cand;
            end
        end else begin
            ev       = is_armed ? EV_KILL : EV_NONE;
            hold_upd = hold_reg;
        end

        case (mode_new)
            MODE_LOW:  mr = MR_MANUAL;
            MODE_MID:  mr = MR_ATTITUDE;
            MODE_HIGH: mr = MR_NONE;
            default:   mr = MR_NONE;
        endcase
    end

    always_comb begin
        last_frame_next = last_frame_reg;
        last_check_next = last_check_reg;
        hold_next       = hold_reg;
        stick_next      = stick_reg;
        kill_next       = kill_reg;
        mode_next       = mode_reg;
        aux1_next       = aux1_reg;
        aux2_next       = aux2_reg;
        if (take && pass) begin
            last_frame_next = time_ms;
        end
        if (take && good) begin
            last_check_next = time_ms;
            hold_next       = hold_upd;
            stick_next      = stick_new;
            kill_next       = kill_new;
            mode_next       = mode_new;
            aux1_next       = aux1_new;
            aux2_next       = aux2_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_frame_reg <= '0;
            last_check_reg <= '0;
            hold_reg       <= '0;
            stick_reg      <= '0;
            kill_reg       <= 1'b0;
            mode_reg       <= MODE_LOW;
            aux1_reg       <= 1'b0;
            aux2_reg       <= 1'b0;
        end else begin
            last_frame_reg <= last_frame_next;
            last_check_reg <= last_check_next;
            hold_reg       <= hold_next;
            stick_reg      <= stick_next;
            kill_reg       <= kill_next;
            mode_reg       <= mode_next;
            aux1_reg       <= aux1_next;
            aux2_reg       <= aux2_next;
        end
    end

    always_comb begin
        result.accepted      = good;
        result.rc_lost       = pass && lost;
        result.stick_x       = good ? stick_new[0] : stick_reg[0];
        result.stick_y       = good ? stick_new[1] : stick_reg[1];
        result.stick_z       = good ? stick_new[2] : stick_reg[2];
        result.stick_f       = good ? stick_new[3] : stick_reg[3];
        result.kill_on       = good ? kill_new : kill_reg;
        result.mode_position = good ? mode_new : mode_reg;
        result.aux1_on       = good ? aux1_new : aux1_reg;
        result.aux2_on       = good ? aux2_new : aux2_reg;
        result.arm_event     = good ? ev : EV_NONE;
        result.mode_request  = good ? mr : MR_NONE;
    end

endmodule

`default_nettype wire

FILE: src/rc_receiver_arming_handler.sv
// Top level of the RC receiver arming handler: stream ports, configuration and output buffer.
`default_nettype none

// The block takes one radio frame per clock cycle while the skid register is empty, and returns
// one result per frame, in order. A result reaches the master side from an output register
// backed by one skid register, so a stalled master does not stop the next frame from entering.
// The frame gate, failsafe check, stick latch and hold timer all work combinationally on the
// frame as it is taken, since every frame depends on the state the previous one leaves behind.
// Eight channel lanes check ranges and switch thresholds side by side. Configuration writes
// are always ready and take effect on the next frame.

module rc_receiver_arming_handler
    import rcah_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pulse_ch0..pulse_ch7 (12 bits each), time_ms (32 bits)
    input  logic [127:0] s_tdata,
    // is_armed
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accepted, rc_lost, stick_x, stick_y, stick_z, stick_f (12 bits each), kill_on,
    // mode_position (2), aux1_on, aux2_on, arm_event (2), mode_request (2), zero fill
    output logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    cfg_t                  cfg_reg, cfg_next;
    pulse_t      [NumPulses-1:0] pulses;
    lane_flags_t [NumPulses-1:0] flags;
    logic [TimeW-1:0]      time_ms;
    logic                  take;
    result_t               result;
    logic [63:0]           result_data;
    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [63:0]           skid_data_reg, skid_data_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_CHANNEL_MAP:  cfg_next.channel_map        = cfg_data;
                CFG_ARM_THROTTLE: cfg_next.arm_throttle_limit = cfg_data[PulseW-1:0];
                CFG_ARM_YAW:      cfg_next.arm_yaw_limit      = cfg_data[PulseW-1:0];
                CFG_DISARM_YAW:   cfg_next.disarm_yaw_limit   = cfg_data[PulseW-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_map        <= ChannelMapReset;
            cfg_reg.arm_throttle_limit <= ArmThrottleReset;
            cfg_reg.arm_yaw_limit      <= ArmYawReset;
            cfg_reg.disarm_yaw_limit   <= DisarmYawReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        for (int i = 0; i < NumPulses; i++) begin
            pulses[i] = s_tdata[i*PulseW +: PulseW];
        end
        time_ms = s_tdata[NumPulses*PulseW +: TimeW];
    end

    for (genvar g = 0; g < NumPulses; g++) begin : g_lane
        rcah_lane u_lane (
            .pulse (pulses[g]),
            .flags (flags[g])
        );
    end

    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;

    rcah_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .pulses   (pulses),
        .flags    (flags),
        .time_ms  (time_ms),
        .is_armed (s_tuser[0]),
        .cfg      (cfg_reg),
        .result   (result)
    );

    assign result_data = {5'b0,
                          result.mode_request,
                          result.arm_event,
                          result.aux2_on,
                          result.aux1_on,
                          result.mode_position,
                          result.kill_on,
                          result.stick_f,
                          result.stick_z,
                          result.stick_y,
                          result.stick_x,
                          result.rc_lost,
                          result.accepted};

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (take) begin
                out_valid_next = 1'b1;
                out_data_next  = result_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: src/rcah_checker.sv
// Port-level checker of the RC receiver arming handler, bound to the top level.
`default_nettype none

`include "rc_receiver_arming_handler_defines.svh"

module rcah_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [63:0]  m_tdata
);

    // A frame is never both accepted and reported lost.
    `RCAH_ASSERT_IMP(a_acc_lost_excl, aclk, aresetn, m_tvalid, !(m_tdata[0] && m_tdata[1]))

    // Events and mode requests come only from accepted frames.
    `RCAH_ASSERT_IMP(a_event_needs_acc, aclk, aresetn, m_tvalid && |m_tdata[56:55], m_tdata[0])
    `RCAH_ASSERT_IMP(a_mode_req_acc, aclk, aresetn, m_tvalid && |m_tdata[58:57], m_tdata[0])

    // A stalled result stays on the bus unchanged.
    `RCAH_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind rc_receiver_arming_handler rcah_checker u_rcah_checker (.*);

`default_nettype wire

FILE: tb/sv/rc_receiver_arming_handler_tb.sv
// Self-checking testbench for the RC receiver arming handler with a frame-level predictor.
`default_nettype none

module rc_receiver_arming_handler_tb;
    import rcah_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumPhases      = 5;
    localparam int FramesPerPhase = 190;
    localparam int StallAfter     = 300;
    localparam int StallCycles    = 200;
    localparam int CalmFrames     = 150;

    typedef struct packed {
        logic                             armed;
        logic [TimeW-1:0]                 stamp;
        logic [NumPulses-1:0][PulseW-1:0] pulse;
    } frame_t;

    typedef struct packed {
        frame_t  frame;
        logic    typed;
        result_t want;
    } table_row_t;

    typedef enum logic [2:0] {
        SC_ARM,
        SC_DISARM,
        SC_KILL,
        SC_FREE,
        SC_NOISE
    } scene_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [23:0]  cfg_data;

    rc_receiver_arming_handler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Configuration and state as the handler should hold them.
    logic [MapW-1:0]  map_cfg;
    pulse_t           thr_limit_cfg;
    pulse_t           arm_yaw_cfg;
    pulse_t           disarm_yaw_cfg;
    logic [TimeW-1:0] gate_time;
    logic [TimeW-1:0] check_time;
    logic [TimeW-1:0] hold_ms;
    pulse_t           stick_latch [NumSticks];
    logic             kill_latch;
    mode_pos_t        mode_latch;
    logic             aux1_latch;
    logic             aux2_latch;

    result_t          awaited_outcomes [$];
    table_row_t       directed_rows [$];
    logic [TimeW-1:0] stamp_now;
    int               frames_taken;
    int               errors;
    logic             calm;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 200_000);
        $display("tb: failure");
        $finish;
    end

    function automatic int slot_chan(input int slot);
        return int'(map_cfg[3*slot +: 3]);
    endfunction

    function automatic result_t latched_view(input logic acc, input logic lost,
                                             input arm_event_t ev, input mode_request_t mr);
        result_t r;
        r.accepted      = acc;
        r.rc_lost       = lost;
        r.stick_x       = stick_latch[0];
        r.stick_y       = stick_latch[1];
        r.stick_z       = stick_latch[2];
        r.stick_f       = stick_latch[3];
        r.kill_on       = kill_latch;
        r.mode_position = mode_latch;
        r.aux1_on       = aux1_latch;
        r.aux2_on       = aux2_latch;
        r.arm_event     = ev;
        r.mode_request  = mr;
        return r;
    endfunction

    function automatic result_t judge_frame(input frame_t f);
        int               i;
        logic             lost;
        logic             in_pos;
        logic [TimeW-1:0] dt;
        logic [TimeW-1:0] sum;
        pulse_t           thr;
        pulse_t           yaw;
        pulse_t           mode_pulse;
        arm_event_t       ev;
        mode_request_t    mr;
        if (f.stamp - gate_time < FrameGap) begin
            return latched_view(1'b0, 1'b0, EV_NONE, MR_NONE);
        end
        gate_time = f.stamp;
        lost = 1'b0;
        for (i = 0; i < NumChannels; i++) begin
            if (f.pulse[i] < PulseMin || f.pulse[i] > PulseMax) begin
                lost = 1'b1;
            end
        end
        if (lost) begin
            return latched_view(1'b0, 1'b1, EV_NONE, MR_NONE);
        end
        for (i = 0; i < NumSticks; i++) begin
            stick_latch[i] = f.pulse[slot_chan(i)];
        end
        mode_pulse = f.pulse[slot_chan(SlotMode)];
        if (mode_pulse > ModeHigh) begin
            mode_latch = MODE_HIGH;
        end else if (mode_pulse > ModeMid) begin
            mode_latch = MODE_MID;
        end else begin
            mode_latch = MODE_LOW;
        end
        kill_latch = f.pulse[slot_chan(SlotKill)] > SwitchMid;
        aux1_latch = f.pulse[slot_chan(SlotAux1)] > SwitchMid;
        aux2_latch = f.pulse[slot_chan(SlotAux2)] > SwitchMid;

        dt = f.stamp - check_time;
        check_time = f.stamp;
        thr = stick_latch[SlotThrust];
        yaw = stick_latch[SlotYaw];
        ev = EV_NONE;
        if (kill_latch) begin
            if (!f.armed) begin
                in_pos = thr < thr_limit_cfg && yaw > arm_yaw_cfg;
            end else begin
                in_pos = thr < thr_limit_cfg && yaw < disarm_yaw_cfg;
            end
            if (in_pos) begin
                sum = hold_ms + dt;
                hold_ms = (sum < hold_ms) ? '1 : sum;
            end else begin
                hold_ms = '0;
            end
            if (hold_ms > HoldLimit) begin
                hold_ms = '0;
                ev = f.armed ? EV_DISARM : EV_ARM;
            end
        end else if (f.armed) begin
            ev = EV_KILL;
        end

        case (mode_latch)
            MODE_HIGH: mr = MR_NONE;
            MODE_MID:  mr = MR_ATTITUDE;
            default:   mr = MR_MANUAL;
        endcase
        return latched_view(1'b1, 1'b0, ev, mr);
    endfunction

    function automatic frame_t frame_of(input int p0, input int p1, input int p2, input int p3,
                                        input int p4, input int p5, input int p6, input int p7,
                                        input logic [TimeW-1:0] stamp, input logic armed);
        frame_t f;
        f.pulse = {p7[11:0], p6[11:0], p5[11:0], p4[11:0],
                   p3[11:0], p2[11:0], p1[11:0], p0[11:0]};
        f.stamp = stamp;
        f.armed = armed;
        return f;
    endfunction

    function automatic frame_t random_frame(input scene_t sc);
        frame_t f;
        int     roll;
        int     i;
        roll = $urandom_range(99);
        if (roll < 8) begin
            stamp_now += $urandom_range(0, 19);
        end else if (roll < 11) begin
            stamp_now = $urandom;
        end else begin
            stamp_now += $urandom_range(20, 400);
        end
        f.stamp = stamp_now;
        f.armed = 1'($urandom_range(1));
        for (i = 0; i < NumPulses; i++) begin
            f.pulse[i] = PulseW'($urandom_range(PulseMin, PulseMax));
        end
        case (sc)
            SC_ARM, SC_DISARM: begin
                f.armed = (sc == SC_DISARM);
                f.pulse[slot_chan(SlotThrust)] = PulseW'($urandom_range(900, 1090));
                f.pulse[slot_chan(SlotYaw)] = (sc == SC_ARM) ? PulseW'($urandom_range(1910, 2200))
                                                              : PulseW'($urandom_range(900, 1090));
                f.pulse[slot_chan(SlotKill)] = PulseW'($urandom_range(1515, 2200));
            end
            SC_KILL: begin
                f.pulse[slot_chan(SlotKill)] = PulseW'($urandom_range(900, 1514));
            end
            SC_NOISE: begin
                for (i = 0; i < NumPulses; i++) begin
                    f.pulse[i] = PulseW'($urandom_range(4095));
                end
            end
            default: ;
        endcase
        if (sc != SC_NOISE && $urandom_range(15) == 0) begin
            f.pulse[$urandom_range(NumPulses - 1)] =
                $urandom_range(1) ? PulseW'($urandom_range(0, 899))
                                  : PulseW'($urandom_range(2201, 4095));
        end
        return f;
    endfunction

    task automatic add_row(input frame_t f, input logic typed, input result_t want);
        table_row_t row;
        row.frame = f;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_frame(input frame_t f, input logic typed, input result_t want);
        result_t outcome;
        while (!calm && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {f.stamp, f.pulse};
        s_tuser  <= f.armed;
        do @(posedge aclk); while (!s_tready);
        frames_taken++;
        outcome = judge_frame(f);
        awaited_outcomes.push_back(typed ? want : outcome);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CHANNEL_MAP:  map_cfg        = value;
            CFG_ARM_THROTTLE: thr_limit_cfg  = value[PulseW-1:0];
            CFG_ARM_YAW:      arm_yaw_cfg    = value[PulseW-1:0];
            default:          disarm_yaw_cfg = value[PulseW-1:0];
        endcase
    endtask

    task automatic configure(input logic [MapW-1:0] map, input pulse_t thr,
                             input pulse_t arm_yaw, input pulse_t disarm_yaw);
        write_reg(CFG_CHANNEL_MAP, map);
        write_reg(CFG_ARM_THROTTLE, {12'd0, thr});
        write_reg(CFG_ARM_YAW, {12'd0, arm_yaw});
        write_reg(CFG_DISARM_YAW, {12'd0, disarm_yaw});
        cfg_valid <= 1'b0;
    endtask

    task automatic await_drain();
        while (awaited_outcomes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    initial begin : receiver
        int cnt;
        logic stall_done;
        stall_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!stall_done && frames_taken >= StallAfter) begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                for (cnt = 0; cnt < StallCycles; cnt++) begin
                    @(posedge aclk);
                end
            end
            m_tready <= calm || $urandom_range(99) >= 9;
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_outcomes.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %h", $time, m_tdata);
            end else begin
                want = awaited_outcomes.pop_front();
                compare_field("accepted", 32'(want.accepted), 32'(m_tdata[0]));
                compare_field("rc_lost", 32'(want.rc_lost), 32'(m_tdata[1]));
                compare_field("stick_x", 32'(want.stick_x), 32'(m_tdata[13:2]));
                compare_field("stick_y", 32'(want.stick_y), 32'(m_tdata[25:14]));
                compare_field("stick_z", 32'(want.stick_z), 32'(m_tdata[37:26]));
                compare_field("stick_f", 32'(want.stick_f), 32'(m_tdata[49:38]));
                compare_field("kill_on", 32'(want.kill_on), 32'(m_tdata[50]));
                compare_field("mode_position", 32'(want.mode_position), 32'(m_tdata[52:51]));
                compare_field("aux1_on", 32'(want.aux1_on), 32'(m_tdata[53]));
                compare_field("aux2_on", 32'(want.aux2_on), 32'(m_tdata[54]));
                compare_field("arm_event", 32'(want.arm_event), 32'(m_tdata[56:55]));
                compare_field("mode_request", 32'(want.mode_request), 32'(m_tdata[58:57]));
            end
        end
    end

    initial begin : stimulus
        int         phase;
        int         n;
        int         i;
        int         roll;
        int         burst_left;
        scene_t     sc;
        result_t    blank;
        result_t    lost_blank;
        table_row_t row;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHANNEL_MAP;
        cfg_data  = '0;
        calm      = 1'b0;
        errors    = 0;
        frames_taken = 0;
        stamp_now = '0;
        burst_left = 0;
        sc = SC_FREE;

        map_cfg        = ChannelMapReset;
        thr_limit_cfg  = ArmThrottleReset;
        arm_yaw_cfg    = ArmYawReset;
        disarm_yaw_cfg = DisarmYawReset;
        gate_time  = '0;
        check_time = '0;
        hold_ms    = '0;
        for (i = 0; i < NumSticks; i++) begin
            stick_latch[i] = '0;
        end
        kill_latch = 1'b0;
        mode_latch = MODE_LOW;
        aux1_latch = 1'b0;
        aux2_latch = 1'b0;

        blank = '0;
        lost_blank = '0;
        lost_blank.rc_lost = 1'b1;

        // Gate, failsafe, extremes, switch thresholds and the arm and disarm hold under the reset configuration.
        add_row(frame_of(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 32'd0, 1'b0), 1'b1, blank);
        add_row(frame_of( 899, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 32'd20, 1'b1),
                1'b1, lost_blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1500, 1500, 1500, 2201, 32'd40, 1'b0),
                1'b1, lost_blank);
        add_row(frame_of(1500, 1500, 1500,    0, 1500, 4095, 1500, 1500, 32'd60, 1'b1),
                1'b1, lost_blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 32'd65, 1'b1), 1'b1, blank);
        add_row(frame_of( 900, 2200,  900, 2200, 2200,  900,  900, 2200, 32'd80, 1'b0), 1'b0, blank);
        add_row(frame_of(1500, 1500, 2000, 1000, 2000, 1500, 1500, 1500, 32'd100, 1'b0), 1'b0, blank);
        add_row(frame_of(1500, 1500, 2000, 1000, 2000, 1500, 1500, 1500, 32'd600, 1'b0), 1'b0, blank);
        add_row(frame_of(1500, 1500, 2000, 1000, 2000, 1500, 1500, 1500, 32'd1100, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1000, 1000, 2000, 1500, 1500, 1500, 32'd1200, 1'b1),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1000, 1000, 2000, 1500, 1500, 1500, 32'd2200, 1'b1),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1000, 1500, 1500, 1500, 32'd2300, 1'b1),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1000, 1500, 1500, 1500, 32'd2400, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1000, 1240, 1514, 1514, 32'd2420, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1000, 1241, 1515, 1515, 32'd2440, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1000, 1790, 1500, 1500, 32'd2460, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1000, 1791, 1500, 1500, 32'd2480, 1'b0),
                1'b0, blank);
        // A huge elapsed time on a partly held stick must saturate the hold timer.
        add_row(frame_of(1500, 1500, 2000, 1000, 2000, 1500, 1500, 1500, 32'd3000, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 2000, 1000, 2000, 1500, 1500, 1500, 32'd2984, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 32'hFFFF_FFFF, 1'b1),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 32'h0000_0013, 1'b0),
                1'b0, blank);
        add_row(frame_of(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500, 32'h0000_0026, 1'b1),
                1'b0, blank);
        add_row(frame_of(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 32'h0000_0040, 1'b0),
                1'b0, blank);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            send_frame(row.frame, row.typed, row.want);
        end
        stamp_now = 32'h0000_0040;

        for (phase = 0; phase < NumPhases; phase++) begin
            if (phase > 0) begin
                await_drain();
                case (phase)
                    1: configure(MapW'($urandom),
                                 PulseW'($urandom_range(1000, 1400)),
                                 PulseW'($urandom_range(1700, 2000)),
                                 PulseW'($urandom_range(1000, 1300)));
                    2: configure(24'hFF_FFFF, 12'hFFF, 12'h000, 12'hFFF);
                    3: configure(24'h00_0000, 12'h000, 12'hFFF, 12'h000);
                    default: configure(ChannelMapReset, ArmThrottleReset, ArmYawReset,
                                       DisarmYawReset);
                endcase
            end
            for (n = 0; n < FramesPerPhase; n++) begin
                if (burst_left == 0) begin
                    roll = $urandom_range(99);
                    if (roll < 30) begin
                        sc = SC_ARM;
                    end else if (roll < 50) begin
                        sc = SC_DISARM;
                    end else if (roll < 62) begin
                        sc = SC_KILL;
                    end else if (roll < 80) begin
                        sc = SC_FREE;
                    end else begin
                        sc = SC_NOISE;
                    end
                    burst_left = $urandom_range(4, 16);
                end
                calm = (phase == 3 && n < CalmFrames);
                send_frame(random_frame(sc), 1'b0, blank);
                burst_left--;
            end
            s_tvalid <= 1'b0;
        end

        await_drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/rcah_pkg.sv
src/rcah_lane.sv
src/rcah_merge.sv
src/rc_receiver_arming_handler.sv
src/rcah_checker.sv
tb/sv/rc_receiver_arming_handler_tb.sv
